### sv/nsv_pkg.sv
`default_nettype none
package nsv_pkg;

	localparam int unsigned MaxLenW = 10;
	localparam int unsigned CountW = 11;
	localparam int unsigned AddrW = 3;
	localparam int unsigned DataW = 32;
	localparam logic [MaxLenW-1:0] MaxLenReset = 10'd400;
	localparam int unsigned TokenDepthDef = 4;
	localparam int unsigned ResultDepthDef = 4;

	localparam logic RegMaxBodyLength = 1'b0;

	localparam logic [1:0] StatusValid = 2'd0;
	localparam logic [1:0] StatusReject = 2'd1;
	localparam logic [1:0] StatusIncomplete = 2'd2;

	localparam logic [7:0] CharDollar = 8'h24;
	localparam logic [7:0] CharStar = 8'h2a;
	localparam logic [7:0] CharCr = 8'h0d;
	localparam logic [7:0] CharLf = 8'h0a;
	localparam logic [7:0] CharBackslash = 8'h5c;
	localparam logic [7:0] CharBang = 8'h21;
	localparam logic [7:0] CharTilde = 8'h7e;
	localparam logic [7:0] PrintLow = 8'h20;
	localparam logic [7:0] PrintHigh = 8'h7e;
	localparam logic [7:0] CharZero = 8'h30;
	localparam logic [7:0] CharUpperA = 8'h41;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       buffer_end;
	} nsv_in_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [CountW-1:0] sentence_length;
		logic [7:0]        checksum_value;
	} nsv_out_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
		logic       is_dollar;
		logic       is_star;
		logic       is_cr;
		logic       is_lf;
		logic       body_bad;
	} nsv_token_t;

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] wide;
		wide = {4'b0000, nib};
		if (nib < 4'd10) begin
			return CharZero + wide;
		end
		return CharUpperA + (wide - 8'd10);
	endfunction

endpackage
`default_nettype wire

### sv/nsv_queue.sv
`default_nettype none
module nsv_queue #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [WIDTH-1:0] din,
	input  wire logic             pop,
	output logic                  empty,
	output logic      [WIDTH-1:0] dout
);
	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;
	logic             do_push;
	logic             do_pop;

	assign full = (count_q == CntW'(DEPTH));
	assign empty = (count_q == '0);
	assign dout = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CntW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CntW'(1);
			end
		end
	end
endmodule
`default_nettype wire

### sv/nsv_front.sv
`default_nettype none
module nsv_front (
	input  wire nsv_pkg::nsv_in_t in_data,
	output nsv_pkg::nsv_token_t   token
);
	import nsv_pkg::*;

	logic [7:0] b;

	assign b = in_data.data_byte;

	always_comb begin
		token.data_byte = b;
		token.last = in_data.buffer_end;
		token.is_dollar = (b == CharDollar);
		token.is_star = (b == CharStar);
		token.is_cr = (b == CharCr);
		token.is_lf = (b == CharLf);
		token.body_bad = (b < PrintLow) || (b > PrintHigh) ||
			(b inside {CharDollar, CharBackslash, CharBang, CharTilde});
	end
endmodule
`default_nettype wire

### sv/nsv_back.sv
`default_nettype none
module nsv_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [nsv_pkg::MaxLenW-1:0]   max_body_length,
	input  wire logic                          tok_empty,
	input  wire nsv_pkg::nsv_token_t           tok,
	output logic                               tok_pop,
	input  wire logic                          res_full,
	output logic                               res_push,
	output nsv_pkg::nsv_out_t                  res
);
	import nsv_pkg::*;

	typedef enum logic [5:0] {
		PH_IDLE = 6'b000001,
		PH_BODY = 6'b000010,
		PH_HEX1 = 6'b000100,
		PH_HEX2 = 6'b001000,
		PH_CR   = 6'b010000,
		PH_LF   = 6'b100000
	} nsv_phase_t;

	nsv_phase_t        phase_q;
	nsv_phase_t        phase_n;
	logic [7:0]        csum_q;
	logic [7:0]        csum_n;
	logic [CountW-1:0] cnt_q;
	logic [CountW-1:0] cnt_n;
	logic [7:0]        first_q;
	logic [7:0]        first_n;
	logic              match_q;
	logic              match_n;
	logic              emit;
	logic              finish;
	logic [1:0]        status;

	assign tok_pop = !tok_empty && !res_full;
	assign res_push = tok_pop && emit;

	always_comb begin
		phase_n = phase_q;
		csum_n = csum_q;
		cnt_n = cnt_q + CountW'(1);
		first_n = first_q;
		match_n = match_q;
		emit = 1'b0;
		finish = 1'b0;
		status = StatusReject;
		case (phase_q)
			PH_IDLE: begin
				cnt_n = cnt_q;
				if (tok.is_dollar) begin
					phase_n = PH_BODY;
					csum_n = '0;
					cnt_n = CountW'(1);
					first_n = '0;
					match_n = 1'b0;
				end
			end
			PH_BODY: begin
				if ((cnt_q > {1'b0, max_body_length}) || tok.body_bad) begin
					emit = 1'b1;
					finish = 1'b1;
				end else if (tok.is_star) begin
					phase_n = PH_HEX1;
				end else begin
					csum_n = csum_q ^ tok.data_byte;
				end
			end
			PH_HEX1: begin
				first_n = tok.data_byte;
				phase_n = PH_HEX2;
			end
			PH_HEX2: begin
				match_n = (first_q == hex_char(csum_q[7:4])) &&
					(tok.data_byte == hex_char(csum_q[3:0]));
				phase_n = PH_CR;
			end
			PH_CR: begin
				if (!tok.is_cr) begin
					emit = 1'b1;
					finish = 1'b1;
				end else begin
					phase_n = PH_LF;
				end
			end
			PH_LF: begin
				emit = 1'b1;
				finish = 1'b1;
				status = (tok.is_lf && match_q) ? StatusValid : StatusReject;
			end
			default: begin
				cnt_n = cnt_q;
				finish = 1'b1;
			end
		endcase
		if (!finish && (phase_n != PH_IDLE) && tok.last) begin
			emit = 1'b1;
			status = StatusIncomplete;
		end
	end

	always_comb begin
		res.status = status;
		res.sentence_length = cnt_n;
		res.checksum_value = csum_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			csum_q <= '0;
			cnt_q <= '0;
			first_q <= '0;
			match_q <= 1'b0;
		end else if (tok_pop) begin
			if (finish) begin
				phase_q <= PH_IDLE;
				csum_q <= '0;
				cnt_q <= '0;
				first_q <= '0;
				match_q <= 1'b0;
			end else begin
				phase_q <= phase_n;
				csum_q <= csum_n;
				cnt_q <= cnt_n;
				first_q <= first_n;
				match_q <= match_n;
			end
		end
	end
endmodule
`default_nettype wire

### sv/nmea_sentence_validator.sv
// Frames NMEA 0183 sentences in a byte stream and checks their checksums. One byte is
// accepted per clock while full is low; each byte is classified on entry, waits in a
// short token queue, and is then consumed by the framing state machine at one byte per
// clock while the result queue is not full, so one byte per cycle is sustained while
// results are popped. A result goes from the framer into the result queue and waits
// at the output ports until popped. A result (valid, rejected, or incomplete at a
// buffer end) is emitted for a sentence's closing or rejecting byte, or for a byte
// marked as buffer end that leaves a sentence open; that open sentence continues with
// the following bytes. The front stalls only when the token queue is full, and the
// framer stalls only when the result queue is full. max_body_length is written through
// the APB port while no transfer is in flight, a user rule the block does not enforce.
`default_nettype none
module nmea_sentence_validator #(
	parameter int unsigned TOKEN_DEPTH = nsv_pkg::TokenDepthDef,
	parameter int unsigned RESULT_DEPTH = nsv_pkg::ResultDepthDef
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        push,
	output logic                             full,
	input  wire nsv_pkg::nsv_in_t            in_data,
	output logic                             empty,
	input  wire logic                        pop,
	output nsv_pkg::nsv_out_t                out_data,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [nsv_pkg::AddrW-1:0]   paddr,
	input  wire logic [nsv_pkg::DataW-1:0]   pwdata,
	output logic      [nsv_pkg::DataW-1:0]   prdata,
	output logic                             pready
);
	import nsv_pkg::*;

	logic [MaxLenW-1:0] max_len_q;
	nsv_token_t         tok_in;
	nsv_token_t         tok_out;
	logic               tok_empty;
	logic               tok_pop;
	logic               res_full;
	logic               res_push;
	nsv_out_t           res;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == RegMaxBodyLength) ?
		{{(DataW - MaxLenW){1'b0}}, max_len_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MaxLenReset;
		end else if (psel && penable && pwrite && pready && (paddr[2] == RegMaxBodyLength)) begin
			max_len_q <= pwdata[MaxLenW-1:0];
		end
	end

	nsv_front u_front (
		.in_data(in_data),
		.token  (tok_in)
	);

	nsv_queue #(
		.WIDTH($bits(nsv_token_t)),
		.DEPTH(TOKEN_DEPTH)
	) u_tok_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.full  (full),
		.din   (tok_in),
		.pop   (tok_pop),
		.empty (tok_empty),
		.dout  (tok_out)
	);

	nsv_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.max_body_length(max_len_q),
		.tok_empty      (tok_empty),
		.tok            (tok_out),
		.tok_pop        (tok_pop),
		.res_full       (res_full),
		.res_push       (res_push),
		.res            (res)
	);

	nsv_queue #(
		.WIDTH($bits(nsv_out_t)),
		.DEPTH(RESULT_DEPTH)
	) u_res_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.full  (res_full),
		.din   (res),
		.pop   (pop),
		.empty (empty),
		.dout  (out_data)
	);
endmodule
`default_nettype wire

### sv/nsv_checker.sv
`default_nettype none
module nsv_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        empty,
	input wire logic                        pop,
	input wire nsv_pkg::nsv_out_t           out_data
);
	import nsv_pkg::*;

	// A waiting result transfer holds until it is popped.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_data))
		else $error("result changed before it was popped");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (out_data.status == StatusValid) || (out_data.status == StatusReject) ||
			(out_data.status == StatusIncomplete))
		else $error("unused status code");

	// A valid sentence holds at least the dollar, star, two digits, CR and LF.
	a_valid_length: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (out_data.status == StatusValid) |->
			(out_data.sentence_length >= 11'd6) && (out_data.sentence_length <= 11'd1028))
		else $error("valid sentence length out of range");

	a_reject_length: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (out_data.status == StatusReject) |->
			(out_data.sentence_length >= 11'd2) && (out_data.sentence_length <= 11'd1028))
		else $error("rejected sentence length out of range");

	a_incomplete_length: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && (out_data.status == StatusIncomplete) |->
			(out_data.sentence_length >= 11'd1) && (out_data.sentence_length <= 11'd1027))
		else $error("incomplete sentence length out of range");
endmodule

bind nmea_sentence_validator nsv_checker u_nsv_checker (.*);
`default_nettype wire

### test/tb_nmea_sentence_validator.sv
`timescale 1ns / 100ps
module tb_nmea_sentence_validator;
	import nsv_pkg::*;

	localparam int SettleCycles = 16;
	localparam int PhaseBudget = 135;
	localparam logic [AddrW-1:0] MaxLenAddr = AddrW'(RegMaxBodyLength) << 2;

	typedef logic [7:0] byte_q_t[$];

	typedef enum logic [2:0] {
		PhHunt, PhBody, PhDigitHi, PhDigitLo, PhWaitCr, PhWaitLf
	} frame_phase_t;

	class sentence_scoreboard;
		frame_phase_t phase;
		logic [MaxLenW-1:0] body_limit;
		logic [7:0] xor_sum;
		logic [CountW-1:0] taken;
		logic [7:0] digit_hi;
		logic sum_ok;
		nsv_out_t awaited[$];
		int errors;

		function new();
			body_limit = MaxLenReset;
			errors = 0;
			restart();
		endfunction

		function void restart();
			phase = PhHunt;
			xor_sum = '0;
			taken = '0;
			digit_hi = '0;
			sum_ok = 1'b0;
		endfunction

		function logic [7:0] hex_digit(logic [3:0] nib);
			string digits;
			digits = "0123456789ABCDEF";
			return digits[nib];
		endfunction

		function bit body_char_ok(logic [7:0] b);
			return b >= PrintLow && b <= PrintHigh &&
				!(b inside {CharDollar, CharBackslash, CharBang, CharTilde});
		endfunction

		function void note_result(logic [1:0] code);
			nsv_out_t r;
			r.status = code;
			r.sentence_length = taken;
			r.checksum_value = xor_sum;
			awaited.push_back(r);
		endfunction

		function void note_byte(nsv_in_t item);
			logic [7:0] b;
			bit closed;
			b = item.data_byte;
			closed = 1'b0;
			case (phase)
				PhHunt: begin
					if (b == CharDollar) begin
						restart();
						phase = PhBody;
						taken = CountW'(1);
					end
				end
				PhBody: begin
					taken = taken + 1'b1;
					if (taken - 1'b1 > body_limit || (b != CharStar && !body_char_ok(b))) begin
						note_result(StatusReject);
						restart();
						closed = 1'b1;
					end else if (b == CharStar) begin
						phase = PhDigitHi;
					end else begin
						xor_sum = xor_sum ^ b;
					end
				end
				PhDigitHi: begin
					taken = taken + 1'b1;
					digit_hi = b;
					phase = PhDigitLo;
				end
				PhDigitLo: begin
					taken = taken + 1'b1;
					sum_ok = digit_hi == hex_digit(xor_sum[7:4]) && b == hex_digit(xor_sum[3:0]);
					phase = PhWaitCr;
				end
				PhWaitCr: begin
					taken = taken + 1'b1;
					if (b != CharCr) begin
						note_result(StatusReject);
						restart();
						closed = 1'b1;
					end else begin
						phase = PhWaitLf;
					end
				end
				PhWaitLf: begin
					taken = taken + 1'b1;
					note_result((b == CharLf && sum_ok) ? StatusValid : StatusReject);
					restart();
					closed = 1'b1;
				end
				default: restart();
			endcase
			if (!closed && item.buffer_end && phase != PhHunt) begin
				note_result(StatusIncomplete);
			end
		endfunction

		task report(string what);
			errors++;
			$display("%0t mismatch: %s", $time, what);
		endtask

		task check_result(nsv_out_t got);
			nsv_out_t want;
			if (awaited.size() == 0) begin
				report($sformatf("result with nothing pending: status %0d length %0d checksum %02h",
					got.status, got.sentence_length, got.checksum_value));
				return;
			end
			want = awaited.pop_front();
			if (got.status !== want.status) begin
				report($sformatf("status %0d, want %0d", got.status, want.status));
			end
			if (got.sentence_length !== want.sentence_length) begin
				report($sformatf("sentence_length %0d, want %0d",
					got.sentence_length, want.sentence_length));
			end
			if (got.checksum_value !== want.checksum_value) begin
				report($sformatf("checksum_value %02h, want %02h",
					got.checksum_value, want.checksum_value));
			end
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic push;
	logic full;
	nsv_in_t in_data;
	logic empty;
	logic pop;
	nsv_out_t out_data;
	logic psel;
	logic penable;
	logic pwrite;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	logic pready;

	sentence_scoreboard sb;
	int burst_left = 0;

	nmea_sentence_validator uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.in_data(in_data),
		.empty(empty),
		.pop(pop),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("nmea_sentence_validator regression: fail");
		$finish;
	end

	// The receiver cycles through free running, coin-flip, periodic and sparse popping.
	initial begin
		int unsigned tick;
		tick = 0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			case ((tick / 97) % 4)
				0: pop = 1'b1;
				1: pop = 1'($urandom_range(0, 1));
				2: pop = (tick % 8) < 2;
				default: pop = $urandom_range(0, 4) == 0;
			endcase
			tick++;
		end
	end

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			sb.check_result(out_data);
		end
	end

	task automatic feed_byte(input logic [7:0] b, input logic be);
		nsv_in_t item;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 2) != 0) begin
				push = 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
			end
		end
		burst_left--;
		item.data_byte = b;
		item.buffer_end = be;
		in_data = item;
		push = 1'b1;
		@(posedge clk);
		while (full) @(posedge clk);
		sb.note_byte(item);
		@(negedge clk);
	endtask

	task automatic feed_text(input string s, input bit be_last);
		for (int i = 0; i < s.len(); i++) begin
			feed_byte(s[i], be_last && i == s.len() - 1);
		end
	endtask

	task automatic write_reg(input logic [AddrW-1:0] addr, input logic [DataW-1:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = addr;
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic settle();
		push = 1'b0;
		while (sb.awaited.size() != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	function automatic logic [7:0] body_char();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(PrintLow, PrintHigh));
		end while (c inside {CharDollar, CharBackslash, CharBang, CharTilde, CharStar});
		return c;
	endfunction

	function automatic logic [7:0] bad_char();
		case ($urandom_range(0, 5))
			0: return 8'($urandom_range(0, PrintLow - 1));
			1: return 8'($urandom_range(PrintHigh + 1, 255));
			2: return CharDollar;
			3: return CharBackslash;
			4: return CharBang;
			default: return CharTilde;
		endcase
	endfunction

	function automatic logic [7:0] other_than(input logic [7:0] x);
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (c == x);
		return c;
	endfunction

	task automatic build_sentence(input logic [MaxLenW-1:0] limit, input int fixed_len,
		output byte_q_t line);
		int kind;
		int len;
		int room;
		logic [7:0] c;
		logic [7:0] sum;
		logic [7:0] hi;
		logic [7:0] lo;
		logic [7:0] cr;
		logic [7:0] lf;
		line = {};
		kind = (fixed_len >= 0) ? 0 : $urandom_range(0, 15);
		room = (limit > 40) ? 40 : int'(limit) - 1;
		if (fixed_len >= 0) begin
			len = fixed_len;
		end else if (kind == 9 && limit <= 60) begin
			len = int'(limit) + $urandom_range(0, 3);
		end else if (room < 0) begin
			len = $urandom_range(0, 3);
		end else begin
			len = $urandom_range(0, room);
		end
		sum = '0;
		line.push_back(CharDollar);
		repeat (len) begin
			c = body_char();
			sum ^= c;
			line.push_back(c);
		end
		hi = sb.hex_digit(sum[7:4]);
		lo = sb.hex_digit(sum[3:0]);
		cr = CharCr;
		lf = CharLf;
		case (kind)
			10: line.insert($urandom_range(1, len + 1), bad_char());
			11: begin
				if ($urandom_range(0, 1) == 0) begin
					hi = other_than(hi);
				end else begin
					lo = other_than(lo);
				end
			end
			12: begin
				hi |= 8'h20;
				lo |= 8'h20;
			end
			13: cr = other_than(CharCr);
			14: lf = other_than(CharLf);
			default: ;
		endcase
		line.push_back(CharStar);
		line.push_back(hi);
		line.push_back(lo);
		line.push_back(cr);
		line.push_back(lf);
		if (kind == 15) begin
			repeat ($urandom_range(1, line.size() - 1)) void'(line.pop_back());
		end
	endtask

	task automatic send_line(input byte_q_t line);
		foreach (line[i]) begin
			feed_byte(line[i], $urandom_range(0, 9) == 0);
		end
	endtask

	task automatic run_phase(input logic [MaxLenW-1:0] limit, input int budget);
		byte_q_t line;
		int used;
		settle();
		write_reg(MaxLenAddr, DataW'(limit));
		sb.body_limit = limit;
		used = 0;
		if (limit == {MaxLenW{1'b1}}) begin
			build_sentence(limit, int'(limit) - 1, line);
			send_line(line);
		end
		while (used < budget) begin
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					feed_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				end
			end
			build_sentence(limit, -1, line);
			send_line(line);
			used += line.size();
		end
	endtask

	initial begin
		logic [MaxLenW-1:0] settings [6];
		sb = new();
		arst_n = 1'b0;
		push = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		feed_byte(8'hff, 1'b1);
		feed_byte(8'h00, 1'b0);
		feed_text("$A*41", 1'b0);
		feed_byte(CharCr, 1'b0);
		feed_byte(CharLf, 1'b0);
		feed_text("$~", 1'b0);
		feed_text("$Z*5a", 1'b0);
		feed_byte(CharCr, 1'b0);
		feed_byte(CharLf, 1'b0);
		feed_text("$B", 1'b1);
		feed_text("*42", 1'b0);
		feed_byte(CharCr, 1'b0);
		feed_byte(CharLf, 1'b0);

		settings = '{10'd1, 10'd1023, 10'd0, MaxLenW'($urandom_range(2, 12)),
			MaxLenW'($urandom_range(13, 60)), MaxLenReset};
		foreach (settings[i]) begin
			run_phase(settings[i], PhaseBudget);
		end
		settle();

		if (sb.errors == 0) begin
			$display("nmea_sentence_validator regression: pass");
		end else begin
			$display("nmea_sentence_validator regression: fail");
		end
		$finish;
	end

endmodule
